/* rtl/virtual_region_pool_allocator_core_assert.svh */
// Assertion macros used by the checker file vrpa_checker.sv.
`ifndef VIRTUAL_REGION_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define VIRTUAL_REGION_POOL_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define VRPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrpa assertion failed");

// next-cycle implication
`define VRPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vrpa assertion failed");

`endif

/* rtl/vrpa_pkg.sv */
package vrpa_pkg;

   localparam int DEFAULT_MAX_REGIONS = 256;
   localparam int DEFAULT_PAGE_BITS   = 12;
   localparam int DEFAULT_ADDR_BITS   = 32;

   localparam int FIELD_BITS     = 32;
   localparam int FREED_BITS     = 21;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [1:0] {
      KIND_ALLOCATE = 2'd0,
      KIND_RELEASE  = 2'd1,
      KIND_CHECK    = 2'd2,
      KIND_NOP      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SPACE   = 2'd1,
      STATUS_TABLE_FULL = 2'd2,
      STATUS_NOT_FOUND  = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POOL_BASE  = 1'b0,
      CSR_POOL_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_CHECK,
      ST_ALLOC_WRITE,
      ST_REL_SCAN,
      ST_REL_DECIDE,
      ST_REL_SHIFT,
      ST_REL_FINISH,
      ST_RESULT
   } state_type;

endpackage

/* rtl/vrpa_ram.sv */
module vrpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/vrpa_space.sv */
module vrpa_space import vrpa_pkg::*; #(
   parameter int PAGE_BITS = DEFAULT_PAGE_BITS
) (
   input  logic [FIELD_BITS-1:0]    pool_base,
   input  logic [FIELD_BITS-1:0]    pool_bytes,
   input  logic [32-PAGE_BITS:0]    used_pages,
   input  logic [FIELD_BITS-1:0]    request_bytes,
   input  logic [FIELD_BITS-1:0]    address,
   output logic [32-PAGE_BITS:0]    request_pages,
   output logic [32-PAGE_BITS:0]    pages_left,
   output logic                     in_pool
);

   localparam int LEN_BITS = 33 - PAGE_BITS;
   localparam int TOT_BITS = 32 - PAGE_BITS;
   localparam logic [FIELD_BITS:0] PAGE_MASK = (FIELD_BITS+1)'((1 << PAGE_BITS) - 1);

   logic [FIELD_BITS:0]   rounded;
   logic [TOT_BITS-1:0]   total;
   logic [LEN_BITS-1:0]   avail;
   logic [FIELD_BITS:0]   pool_end;

   always_comb begin
      rounded       = {1'b0, request_bytes} + PAGE_MASK;
      request_pages = rounded[FIELD_BITS:PAGE_BITS];
      total         = pool_bytes[FIELD_BITS-1:PAGE_BITS];
      avail         = (total != '0) ? LEN_BITS'(total - TOT_BITS'(1)) : '0;
      pages_left    = (avail > used_pages) ? (avail - used_pages) : '0;
      pool_end      = {1'b0, pool_base} + {1'b0, pool_bytes};
      in_pool       = ({1'b0, address} >= {1'b0, pool_base}) && ({1'b0, address} < pool_end);
   end

endmodule

/* rtl/virtual_region_pool_allocator_core.sv */
// Region allocator for a virtual address pool. Each transaction on req_ is an
// allocate, release, address check or no-op and yields exactly one transaction
// on rsp_. Regions live in an ordered table held in a single-port-read RAM; the
// first pool page is an implicit header that is never stored. A release reads
// every stored entry once to find the match, then moves each later entry down
// one place through the same read port. req_stall is high after acceptance until
// the result has entered the output register; the result may wait there while
// the next transaction is taken. The user must write pool_base and pool_bytes
// through csr_ only while no transaction is in flight; the block itself does
// not enforce this.
module virtual_region_pool_allocator_core import vrpa_pkg::*; #(
   parameter int MAX_REGIONS = DEFAULT_MAX_REGIONS,
   parameter int PAGE_BITS   = DEFAULT_PAGE_BITS,
   parameter int ADDR_BITS   = DEFAULT_ADDR_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [FIELD_BITS-1:0]     req_request_bytes,
   input  logic [FIELD_BITS-1:0]     req_address,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [FIELD_BITS-1:0]     rsp_region_base,
   output logic [FREED_BITS-1:0]     rsp_freed_pages,
   output logic                      rsp_legitimate,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]     csr_write_data
);

   localparam int LEN_BITS  = 33 - PAGE_BITS;
   localparam int IDX_BITS  = $clog2(MAX_REGIONS);
   localparam int CNT_BITS  = $clog2(MAX_REGIONS + 1);
   localparam int ENT_BITS  = ADDR_BITS + LEN_BITS;
   localparam int CMP_BITS  = (ADDR_BITS > FIELD_BITS) ? ADDR_BITS : FIELD_BITS;
   localparam logic [ADDR_BITS:0] PAGE_STEP = (ADDR_BITS+1)'(1) << PAGE_BITS;

   state_type               state_ff, state_in;
   logic [FIELD_BITS-1:0]   pool_base_ff, pool_base_in;
   logic [FIELD_BITS-1:0]   pool_bytes_ff, pool_bytes_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [LEN_BITS-1:0]     used_ff, used_in;
   logic [LEN_BITS-1:0]     pages_ff, pages_in;
   logic [FIELD_BITS-1:0]   addr_ff, addr_in;
   logic [IDX_BITS-1:0]     scan_idx_ff, scan_idx_in;
   logic [IDX_BITS-1:0]     hit_ff, hit_in;
   logic [ADDR_BITS-1:0]    hit_base_ff, hit_base_in;
   logic [LEN_BITS-1:0]     hit_len_ff, hit_len_in;
   logic                    found_ff, found_in;
   logic [IDX_BITS-1:0]     dst_ff, dst_in;
   status_type              res_status_ff, res_status_in;
   logic [FIELD_BITS-1:0]   res_base_ff, res_base_in;
   logic [FREED_BITS-1:0]   res_freed_ff, res_freed_in;
   logic                    res_legit_ff, res_legit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [FIELD_BITS-1:0]   rsp_base_ff, rsp_base_in;
   logic [FREED_BITS-1:0]   rsp_freed_ff, rsp_freed_in;
   logic                    rsp_legit_ff, rsp_legit_in;

   logic                    ram_wr_en;
   logic [IDX_BITS-1:0]     ram_wr_addr;
   logic [ENT_BITS-1:0]     ram_wr_data;
   logic                    ram_rd_en;
   logic [IDX_BITS-1:0]     ram_rd_addr;
   logic [ENT_BITS-1:0]     ram_rd_data;
   logic [ADDR_BITS-1:0]    rd_start;
   logic [LEN_BITS-1:0]     rd_len;

   logic [LEN_BITS-1:0]     req_pages;
   logic [LEN_BITS-1:0]     pages_left;
   logic                    in_pool;

   vrpa_ram #(
      .WIDTH (ENT_BITS),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   vrpa_space #(
      .PAGE_BITS (PAGE_BITS)
   ) u_space (
      .pool_base     (pool_base_ff),
      .pool_bytes    (pool_bytes_ff),
      .used_pages    (used_ff),
      .request_bytes (req_request_bytes),
      .address       (req_address),
      .request_pages (req_pages),
      .pages_left    (pages_left),
      .in_pool       (in_pool)
   );

   assign rd_start = ram_rd_data[ENT_BITS-1:LEN_BITS];
   assign rd_len   = ram_rd_data[LEN_BITS-1:0];

   always_comb begin
      logic                 alloc_commit;
      logic [ADDR_BITS-1:0] alloc_base;
      logic                 match;

      state_in      = state_ff;
      pool_base_in  = pool_base_ff;
      pool_bytes_in = pool_bytes_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      pages_in      = pages_ff;
      addr_in       = addr_ff;
      scan_idx_in   = scan_idx_ff;
      hit_in        = hit_ff;
      hit_base_in   = hit_base_ff;
      hit_len_in    = hit_len_ff;
      found_in      = found_ff;
      dst_in        = dst_ff;
      res_status_in = res_status_ff;
      res_base_in   = res_base_ff;
      res_freed_in  = res_freed_ff;
      res_legit_in  = res_legit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_legit_in  = rsp_legit_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[IDX_BITS-1:0];
      ram_wr_data   = {rd_start, rd_len};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      alloc_commit  = 1'b0;
      alloc_base    = ADDR_BITS'(pool_base_ff) + ADDR_BITS'(PAGE_STEP);
      match         = CMP_BITS'(rd_start) == CMP_BITS'(addr_ff);

      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_POOL_BASE:  pool_base_in  = csr_write_data;
            CSR_POOL_BYTES: pool_bytes_in = csr_write_data;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               addr_in       = req_address;
               pages_in      = req_pages;
               res_status_in = STATUS_OK;
               res_base_in   = '0;
               res_freed_in  = '0;
               res_legit_in  = 1'b0;
               found_in      = 1'b0;
               scan_idx_in   = '0;
               unique case (kind_type'(req_kind))
                  KIND_ALLOCATE: state_in = ST_ALLOC_CHECK;
                  KIND_RELEASE: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_NOT_FOUND;
                        state_in      = ST_RESULT;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = ST_REL_SCAN;
                     end
                  end
                  KIND_CHECK: begin
                     res_legit_in = in_pool;
                     state_in     = ST_RESULT;
                  end
                  KIND_NOP: state_in = ST_RESULT;
               endcase
            end
         end
         ST_ALLOC_CHECK: begin
            if (pages_ff > pages_left) begin
               res_status_in = STATUS_NO_SPACE;
               state_in      = ST_RESULT;
            end else if (count_ff >= CNT_BITS'(MAX_REGIONS)) begin
               res_status_in = STATUS_TABLE_FULL;
               state_in      = ST_RESULT;
            end else if (count_ff == '0) begin
               alloc_commit = 1'b1;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_BITS'(count_ff - CNT_BITS'(1));
               state_in    = ST_ALLOC_WRITE;
            end
         end
         ST_ALLOC_WRITE: begin
            alloc_base   = rd_start + ADDR_BITS'({rd_len, {PAGE_BITS{1'b0}}});
            alloc_commit = 1'b1;
         end
         ST_REL_SCAN: begin
            if (match) begin
               hit_in      = scan_idx_ff;
               hit_base_in = rd_start;
               hit_len_in  = rd_len;
               found_in    = 1'b1;
            end
            if (CNT_BITS'(scan_idx_ff) + CNT_BITS'(1) == count_ff) begin
               state_in = ST_REL_DECIDE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_BITS'(CNT_BITS'(scan_idx_ff) + CNT_BITS'(1));
               scan_idx_in = IDX_BITS'(CNT_BITS'(scan_idx_ff) + CNT_BITS'(1));
            end
         end
         ST_REL_DECIDE: begin
            if (!found_ff) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_RESULT;
            end else if (CNT_BITS'(hit_ff) + CNT_BITS'(1) == count_ff) begin
               state_in = ST_REL_FINISH;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_BITS'(CNT_BITS'(hit_ff) + CNT_BITS'(1));
               dst_in      = hit_ff;
               state_in    = ST_REL_SHIFT;
            end
         end
         ST_REL_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = dst_ff;
            ram_wr_data = {rd_start, rd_len};
            if (CNT_BITS'(dst_ff) + CNT_BITS'(2) == count_ff) begin
               state_in = ST_REL_FINISH;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_BITS'(CNT_BITS'(dst_ff) + CNT_BITS'(2));
               dst_in      = IDX_BITS'(CNT_BITS'(dst_ff) + CNT_BITS'(1));
            end
         end
         ST_REL_FINISH: begin
            count_in      = count_ff - CNT_BITS'(1);
            used_in       = (used_ff >= hit_len_ff) ? (used_ff - hit_len_ff) : '0;
            res_status_in = STATUS_OK;
            res_base_in   = FIELD_BITS'(hit_base_ff);
            res_freed_in  = FREED_BITS'(hit_len_ff);
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_base_in   = res_base_ff;
               rsp_freed_in  = res_freed_ff;
               rsp_legit_in  = res_legit_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase

      if (alloc_commit) begin
         ram_wr_en     = 1'b1;
         ram_wr_addr   = count_ff[IDX_BITS-1:0];
         ram_wr_data   = {alloc_base, pages_ff};
         count_in      = count_ff + CNT_BITS'(1);
         used_in       = used_ff + pages_ff;
         res_status_in = STATUS_OK;
         res_base_in   = FIELD_BITS'(alloc_base);
         state_in      = ST_RESULT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pool_base_ff  <= '0;
         pool_bytes_ff <= '0;
         count_ff      <= '0;
         used_ff       <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pool_base_ff  <= pool_base_in;
         pool_bytes_ff <= pool_bytes_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pages_ff      <= pages_in;
      addr_ff       <= addr_in;
      scan_idx_ff   <= scan_idx_in;
      hit_ff        <= hit_in;
      hit_base_ff   <= hit_base_in;
      hit_len_ff    <= hit_len_in;
      dst_ff        <= dst_in;
      res_status_ff <= res_status_in;
      res_base_ff   <= res_base_in;
      res_freed_ff  <= res_freed_in;
      res_legit_ff  <= res_legit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_legit_ff  <= rsp_legit_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_region_base = rsp_base_ff;
   assign rsp_freed_pages = rsp_freed_ff;
   assign rsp_legitimate  = rsp_legit_ff;

endmodule

/* rtl/vrpa_checker.sv */
`include "virtual_region_pool_allocator_core_assert.svh"

module vrpa_checker import vrpa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [1:0]            rsp_status,
   input logic [FIELD_BITS-1:0] rsp_region_base,
   input logic [FREED_BITS-1:0] rsp_freed_pages,
   input logic                  rsp_legitimate
);

   `VRPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_region_base) && $stable(rsp_freed_pages))

   `VRPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   `VRPA_ASSERT_NOW(a_check_only_flag, clock, reset, rsp_valid && rsp_legitimate, rsp_status == STATUS_OK && rsp_region_base == '0 && rsp_freed_pages == '0)

   `VRPA_ASSERT_NOW(a_fail_zero_fields, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_region_base == '0 && rsp_freed_pages == '0 && !rsp_legitimate)

endmodule

bind virtual_region_pool_allocator_core vrpa_checker u_vrpa_checker (.*);

/* verif/tb_virtual_region_pool_allocator_core.sv */
module tb_virtual_region_pool_allocator_core;
   import vrpa_pkg::*;

   localparam int MAX_REGIONS     = DEFAULT_MAX_REGIONS;
   localparam int PAGE_SHIFT      = DEFAULT_PAGE_BITS;
   localparam longint PAGE_BYTES  = longint'(1) << PAGE_SHIFT;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int SETTLE_CYCLES   = 2 * MAX_REGIONS + 100;
   localparam int QUIET_LIMIT     = 20000;
   localparam int SCRIPT_ROWS     = 25;
   localparam int REPORT_CAP      = 200;

   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] region_base;
      logic [FREED_BITS-1:0] freed_pages;
      logic                  legitimate;
   } region_outcome_type;

   typedef struct packed {
      kind_type              kind;
      logic [FIELD_BITS-1:0] request_bytes;
      logic [FIELD_BITS-1:0] address;
      logic                  fixed;
      status_type            status;
      logic [FIELD_BITS-1:0] region_base;
      logic [FREED_BITS-1:0] freed_pages;
      logic                  legitimate;
   } scripted_op_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_kind;
   logic [FIELD_BITS-1:0]     req_request_bytes;
   logic [FIELD_BITS-1:0]     req_address;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_status;
   logic [FIELD_BITS-1:0]     rsp_region_base;
   logic [FREED_BITS-1:0]     rsp_freed_pages;
   logic                      rsp_legitimate;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [FIELD_BITS-1:0]     csr_write_data;

   logic [FIELD_BITS-1:0] pool_base_mirror = '0;
   logic [FIELD_BITS-1:0] pool_bytes_mirror = '0;
   logic [FIELD_BITS-1:0] region_table_start [MAX_REGIONS];
   logic [FREED_BITS-1:0] region_table_pages [MAX_REGIONS];
   int                    region_table_count = 0;
   longint                pages_in_use = 0;

   region_outcome_type awaited_outcomes [$];
   scripted_op_type    script [SCRIPT_ROWS];

   int burst_left = 0;
   bit hold_off_pending = 1'b0;
   int quiet_cycles = 0;
   int errors = 0;
   int reported = 0;
   int transactions = 0;
   int placed = 0;
   int refused_space = 0;
   int refused_full = 0;
   int released = 0;
   int release_misses = 0;
   int checks = 0;
   int inside_pool = 0;

   virtual_region_pool_allocator_core dut (.*);

   always #5 clock = ~clock;

   function automatic longint pages_free();
      longint avail;
      avail = longint'(pool_bytes_mirror >> PAGE_SHIFT);
      avail = (avail >= 1) ? avail - 1 : 0;
      return (avail > pages_in_use) ? avail - pages_in_use : 0;
   endfunction

   function automatic region_outcome_type apply_pool_op(
      input kind_type              k,
      input logic [FIELD_BITS-1:0] bytes,
      input logic [FIELD_BITS-1:0] addr
   );
      region_outcome_type res;
      longint pages;
      int hit;
      logic [FIELD_BITS-1:0] base;
      res = '0;
      case (k)
         KIND_ALLOCATE: begin
            pages = (longint'(bytes) + PAGE_BYTES - 1) >> PAGE_SHIFT;
            if (pages > pages_free()) begin
               res.status = STATUS_NO_SPACE;
            end else if (region_table_count >= MAX_REGIONS) begin
               res.status = STATUS_TABLE_FULL;
            end else begin
               if (region_table_count == 0) begin
                  base = pool_base_mirror + FIELD_BITS'(PAGE_BYTES);
               end else begin
                  base = region_table_start[region_table_count - 1] + FIELD_BITS'(
                     longint'(region_table_pages[region_table_count - 1]) << PAGE_SHIFT);
               end
               region_table_start[region_table_count] = base;
               region_table_pages[region_table_count] = FREED_BITS'(pages);
               region_table_count++;
               pages_in_use += pages;
               res.region_base = base;
            end
         end
         KIND_RELEASE: begin
            hit = -1;
            for (int i = 0; i < region_table_count; i++) begin
               if (region_table_start[i] == addr) hit = i;
            end
            if (hit < 0) begin
               res.status = STATUS_NOT_FOUND;
            end else begin
               res.region_base = region_table_start[hit];
               res.freed_pages = region_table_pages[hit];
               for (int i = hit; i + 1 < region_table_count; i++) begin
                  region_table_start[i] = region_table_start[i + 1];
                  region_table_pages[i] = region_table_pages[i + 1];
               end
               region_table_count--;
               if (pages_in_use >= longint'(res.freed_pages)) begin
                  pages_in_use -= longint'(res.freed_pages);
               end else begin
                  pages_in_use = 0;
               end
            end
         end
         KIND_CHECK: begin
            res.legitimate = (addr >= pool_base_mirror) &&
               ({1'b0, addr} < {1'b0, pool_base_mirror} + {1'b0, pool_bytes_mirror});
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic offer(input kind_type k, input logic [FIELD_BITS-1:0] bytes,
                        input logic [FIELD_BITS-1:0] addr, input logic fixed,
                        input region_outcome_type want);
      region_outcome_type predicted;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_kind <= 2'($urandom);
            req_request_bytes <= $urandom;
            req_address <= $urandom;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_request_bytes <= bytes;
      req_address <= addr;
      do @(posedge clock); while (req_stall);
      burst_left--;
      predicted = apply_pool_op(k, bytes, addr);
      awaited_outcomes.push_back(fixed ? want : predicted);
      transactions++;
      case (k)
         KIND_ALLOCATE: begin
            if (predicted.status == STATUS_OK) placed++;
            else if (predicted.status == STATUS_NO_SPACE) refused_space++;
            else refused_full++;
         end
         KIND_RELEASE: begin
            if (predicted.status == STATUS_OK) released++;
            else release_misses++;
         end
         KIND_CHECK: begin
            checks++;
            if (predicted.legitimate) inside_pool++;
         end
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   task automatic reconfigure(input logic [FIELD_BITS-1:0] base,
                              input logic [FIELD_BITS-1:0] bytes);
      drain();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_POOL_BASE;
      csr_write_data <= base;
      @(posedge clock);
      csr_index <= CSR_POOL_BYTES;
      csr_write_data <= bytes;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pool_base_mirror = base;
      pool_bytes_mirror = bytes;
   endtask

   task automatic clear_table();
      while (region_table_count > 0) begin
         offer(KIND_RELEASE, $urandom,
               region_table_start[$urandom_range(0, region_table_count - 1)], 1'b0, '0);
      end
   endtask

   task automatic random_items(input int count, input int alloc_pct, input int release_pct,
                               input bit compact);
      kind_type k;
      logic [FIELD_BITS-1:0] bytes;
      logic [FIELD_BITS-1:0] addr;
      longint left;
      int r;
      int pick;
      for (int j = 0; j < count; j++) begin
         bytes = $urandom;
         addr = $urandom;
         r = $urandom_range(0, 99);
         pick = $urandom_range(0, 99);
         left = pages_free();
         if (r < alloc_pct) begin
            k = KIND_ALLOCATE;
            if (compact) begin
               if (pick < 30) bytes = '0;
               else if (pick < 90) bytes = $urandom_range(1, PAGE_BYTES);
            end else if (pick < 15) begin
               bytes = '0;
            end else if (pick < 45) begin
               bytes = $urandom_range(1, 4 * PAGE_BYTES);
            end else if (pick < 60) begin
               bytes = $urandom_range(1, 8) << PAGE_SHIFT;
            end else if (pick < 70) begin
               bytes = FIELD_BITS'(left << PAGE_SHIFT);
            end else if (pick < 80) begin
               bytes = FIELD_BITS'(left << PAGE_SHIFT) + 1;
            end
         end else if (r < alloc_pct + release_pct) begin
            k = KIND_RELEASE;
            if (region_table_count > 0 && pick < 70) begin
               addr = region_table_start[$urandom_range(0, region_table_count - 1)];
            end else if (pick < 85) begin
               addr = pool_base_mirror;
            end
         end else if (r < 96) begin
            k = KIND_CHECK;
            if (pick < 15) addr = pool_base_mirror;
            else if (pick < 30) addr = pool_base_mirror - 1;
            else if (pick < 45) addr = pool_base_mirror + pool_bytes_mirror - 1;
            else if (pick < 60) addr = pool_base_mirror + pool_bytes_mirror;
            else if (pick < 75) addr = pool_base_mirror + $urandom_range(0, pool_bytes_mirror);
         end else begin
            k = KIND_NOP;
         end
         offer(k, bytes, addr, 1'b0, '0);
         if ($urandom_range(0, 99) == 0) drain();
      end
   endtask

   task automatic note_mismatch(input string field, input logic [FIELD_BITS-1:0] want,
                                input logic [FIELD_BITS-1:0] got);
      errors++;
      if (reported < REPORT_CAP) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
      reported++;
   endtask

   always @(posedge clock) begin
      region_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_outcomes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual status %0d base 0x%0h",
                     $time, rsp_status, rsp_region_base);
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status) note_mismatch("status", want.status, rsp_status);
            if (rsp_region_base !== want.region_base) begin
               note_mismatch("region_base", want.region_base, rsp_region_base);
            end
            if (rsp_freed_pages !== want.freed_pages) begin
               note_mismatch("freed_pages", want.freed_pages, rsp_freed_pages);
            end
            if (rsp_legitimate !== want.legitimate) begin
               note_mismatch("legitimate", want.legitimate, rsp_legitimate);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int mode;
      int left_in_mode;
      int tick;
      mode = 0;
      left_in_mode = 0;
      tick = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (left_in_mode == 0) begin
               mode = $urandom_range(0, 3);
               left_in_mode = $urandom_range(20, 300);
            end
            left_in_mode--;
            tick++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((tick % 7) < 3);
            endcase
         end
      end
   end

   initial begin
      region_outcome_type typed_want;
      script = '{
         '{KIND_CHECK, 32'h0, 32'h4000_0000, 1'b1, STATUS_OK, 32'h0, 21'h0, 1'b1},
         '{KIND_CHECK, 32'h0, 32'h3FFF_FFFF, 1'b1, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_CHECK, 32'h0, 32'h4000_FFFF, 1'b1, STATUS_OK, 32'h0, 21'h0, 1'b1},
         '{KIND_CHECK, 32'h0, 32'h4001_0000, 1'b1, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_CHECK, 32'h0, 32'h0, 1'b1, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_RELEASE, 32'h0, 32'h4000_0000, 1'b1, STATUS_NOT_FOUND, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h0, 32'h0, 1'b1, STATUS_OK, 32'h4000_1000, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h1, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h1000, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'hFFFF_FFFF, 32'h0, 1'b1, STATUS_NO_SPACE, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h1001, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_RELEASE, 32'h0, 32'h4000_1000, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_RELEASE, 32'h0, 32'h4000_1000, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_RELEASE, 32'h0, 32'h4000_1000, 1'b1, STATUS_NOT_FOUND, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'hB000, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h1001, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h1000, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h0, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h1, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_RELEASE, 32'h0, 32'h4000_3000, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_RELEASE, 32'h0, 32'h4000_2000, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_ALLOCATE, 32'h2000, 32'h0, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0},
         '{KIND_RELEASE, 32'h0, 32'h4001_1000, 1'b0, STATUS_OK, 32'h0, 21'h0, 1'b0}
      };
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= KIND_NOP;
      req_request_bytes <= '0;
      req_address <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_POOL_BASE;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      reconfigure(32'h4000_0000, 32'h0001_0000);
      foreach (script[n]) begin
         typed_want.status = script[n].status;
         typed_want.region_base = script[n].region_base;
         typed_want.freed_pages = script[n].freed_pages;
         typed_want.legitimate = script[n].legitimate;
         offer(script[n].kind, script[n].request_bytes, script[n].address, script[n].fixed,
               typed_want);
      end

      reconfigure(32'h0000_0000, 32'hFFFF_FFFF);
      random_items(60, 45, 30, 1'b0);
      hold_off_pending = 1'b1;
      random_items(90, 45, 30, 1'b0);
      clear_table();

      reconfigure(32'hFFFF_F000, 32'h0000_8000);
      random_items(100, 45, 30, 1'b0);

      reconfigure($urandom, 32'h0000_0000);
      random_items(80, 40, 30, 1'b0);
      clear_table();

      reconfigure({20'($urandom_range(0, 32'hF_FFFF)), 12'h000}, 32'h0080_0000);
      random_items(360, 88, 6, 1'b1);

      reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_items(100, 25, 55, 1'b0);

      reconfigure($urandom, $urandom);
      random_items(50, 45, 30, 1'b0);
      hold_off_pending = 1'b1;
      random_items(50, 45, 30, 1'b0);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d transactions: %0d regions placed, %0d refused for space, %0d full table",
               transactions, placed, refused_space, refused_full);
      $display("%0d releases, %0d release misses, %0d address checks, %0d inside the pool",
               released, release_misses, checks, inside_pool);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
